>>> src/b64d_pkg.sv
// Shared types, constants and the character-to-symbol map for the base64 stream decoder.
// Depends on nothing; imported by every module of the block.
package b64d_pkg;

    localparam int COUNT_BITS = 24;
    localparam int CAP_BITS   = 24;
    localparam int TOTAL_BITS = 24;
    localparam int CMP_BITS   = (COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS;
    localparam int EXT_BITS   = (CMP_BITS > TOTAL_BITS) ? CMP_BITS : TOTAL_BITS;

    localparam logic [7:0] CHAR_PAD = 8'h3D;

    localparam logic [6:0] SYM_PAD  = 7'd64;
    localparam logic [6:0] SYM_SKIP = 7'd127;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_OVERRUN = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic [7:0] char_in;
        logic       msg_end;
    } in_t;

    typedef struct packed {
        logic                  kind;
        logic [7:0]            data_byte;
        logic                  status;
        logic [TOTAL_BITS-1:0] byte_total;
    } out_t;

    // results of one transaction handed to the output queue
    typedef struct packed {
        logic [1:0] count;
        out_t       first;
        out_t       second;
    } push_t;

    function automatic logic [6:0] sym_of(input logic [7:0] c);
        logic [6:0] s;
        if (c inside {[8'h41:8'h5A]})
            s = 7'(c - 8'h41);
        else if (c inside {[8'h61:8'h7A]})
            s = 7'(c - 8'h61 + 8'd26);
        else if (c inside {[8'h30:8'h39]})
            s = 7'(c - 8'h30 + 8'd52);
        else if (c == 8'h2B)
            s = 7'd62;
        else if (c == 8'h2F)
            s = 7'd63;
        else if (c == CHAR_PAD)
            s = SYM_PAD;
        else
            s = SYM_SKIP;
        return s;
    endfunction

endpackage

>>> src/b64d_out_fifo.sv
// Four-entry result queue taking up to two results per cycle and giving one per cycle while out_ready is high.
// Depends on b64d_pkg.
module b64d_out_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  b64d_pkg::push_t push,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output b64d_pkg::out_t  out_data
);
    import b64d_pkg::*;

    out_t                 mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic [FIFO_AW-1:0]   wr_ptr_plus1;
    logic                 pop;

    assign out_valid    = (count_reg != '0);
    assign out_data     = mem_reg[rd_ptr_reg];
    assign pop          = out_valid && out_ready;
    assign room         = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(push.count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(pop);
        count_next  = count_reg + (FIFO_AW+1)'(push.count) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem_reg[wr_ptr_reg] <= push.first;
        if (push.count == 2'd2)
            mem_reg[wr_ptr_plus1] <= push.second;
    end

endmodule

>>> src/b64d_core.sv
// Input register, per-message decode state and the single-pass decode step.
// Depends on b64d_pkg.
module b64d_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  b64d_pkg::in_t                   in_data,
    input  logic                            cfg_wr_en,
    input  logic [b64d_pkg::CAP_BITS-1:0]   cfg_wr_data,
    input  logic                            room,
    output b64d_pkg::push_t                 push
);
    import b64d_pkg::*;

    logic                  in_valid_reg;
    in_t                   in_data_reg;
    logic [CAP_BITS-1:0]   cap_reg;

    logic [1:0]            phase_reg, phase_next;
    logic [7:0]            pending_reg, pending_next;
    logic                  stopped_reg, stopped_next;
    logic                  await_reg, await_next;
    logic                  overrun_reg, overrun_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;

    logic                  fire;
    logic [6:0]            sym;
    logic [5:0]            s6;
    logic                  emit;
    logic [7:0]            byte_val;
    logic                  last;
    logic [COUNT_BITS-1:0] count_inc;
    logic                  cap_hit;
    logic [EXT_BITS-1:0]   total_ext;
    out_t                  data_res;
    out_t                  report_res;

    assign fire     = in_valid_reg && room;
    assign in_ready = !in_valid_reg || fire;
    assign last     = in_data_reg.msg_end;
    assign sym      = sym_of(in_data_reg.char_in);
    assign s6       = sym[5:0];
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;
    assign cap_hit  = (cap_reg != '0) &&
                      (CMP_BITS'(count_inc) >= CMP_BITS'(cap_reg));

    always_comb
    begin
        phase_next   = phase_reg;
        pending_next = pending_reg;
        stopped_next = stopped_reg;
        await_next   = await_reg;
        overrun_next = overrun_reg;
        count_next   = count_reg;
        emit         = 1'b0;
        byte_val     = 8'h00;

        if (!stopped_reg)
        begin
            if (await_reg)
            begin
                await_next   = 1'b0;
                stopped_next = 1'b1;
                if (in_data_reg.char_in != CHAR_PAD)
                    overrun_next = 1'b1;
            end
            else if (sym == SYM_PAD)
            begin
                if (phase_reg == 2'd0)
                    stopped_next = 1'b1;
                phase_next   = 2'd0;
                pending_next = 8'h00;
            end
            else if (sym != SYM_SKIP)
            begin
                case (phase_reg)
                    2'd0:
                    begin
                        pending_next = {s6, 2'b00};
                    end
                    2'd1:
                    begin
                        byte_val     = pending_reg | {6'b0, s6[5:4]};
                        pending_next = {s6[3:0], 4'b0};
                        emit         = 1'b1;
                    end
                    2'd2:
                    begin
                        byte_val     = pending_reg | {4'b0, s6[5:2]};
                        pending_next = {s6[1:0], 6'b0};
                        emit         = 1'b1;
                    end
                    default:
                    begin
                        byte_val     = pending_reg | {2'b0, s6};
                        pending_next = 8'h00;
                        emit         = 1'b1;
                    end
                endcase
                phase_next = phase_reg + 2'd1;
                if (emit)
                begin
                    count_next = count_inc;
                    if (cap_hit)
                    begin
                        if (phase_reg == 2'd3)
                            stopped_next = 1'b1;
                        else if (last)
                        begin
                            stopped_next = 1'b1;
                            overrun_next = 1'b1;
                        end
                        else
                            await_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        total_ext             = EXT_BITS'(count_next);
        data_res.kind         = KIND_DATA;
        data_res.data_byte    = byte_val;
        data_res.status       = STATUS_OK;
        data_res.byte_total   = '0;
        report_res.kind       = KIND_REPORT;
        report_res.data_byte  = 8'h00;
        report_res.status     = overrun_next ? STATUS_OVERRUN : STATUS_OK;
        report_res.byte_total = total_ext[TOTAL_BITS-1:0];

        push.count  = 2'd0;
        push.first  = data_res;
        push.second = report_res;
        if (fire)
        begin
            push.count = {1'b0, emit} + {1'b0, last};
            if (!emit)
                push.first = report_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            cap_reg      <= '0;
            phase_reg    <= '0;
            pending_reg  <= '0;
            stopped_reg  <= 1'b0;
            await_reg    <= 1'b0;
            overrun_reg  <= 1'b0;
            count_reg    <= '0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (fire)
            begin
                if (last)
                begin
                    phase_reg   <= '0;
                    pending_reg <= '0;
                    stopped_reg <= 1'b0;
                    await_reg   <= 1'b0;
                    overrun_reg <= 1'b0;
                    count_reg   <= '0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    pending_reg <= pending_next;
                    stopped_reg <= stopped_next;
                    await_reg   <= await_next;
                    overrun_reg <= overrun_next;
                    count_reg   <= count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_data_reg <= in_data;
    end

endmodule

>>> src/base64_stream_decoder_core.sv
// Top level of the base64 stream decoder: input register and decode step,
// followed by the result queue. Depends on b64d_pkg, b64d_core, b64d_out_fifo.
//
// Use:
//   in_*  : one text character per transaction, msg_end on the last one.
//   out_* : decoded bytes (kind 0) and one report per message (kind 1) with
//           the overrun status and the byte count of the message.
//   cfg_wr_en / cfg_wr_data : byte capacity per message, 0 = no limit;
//           write only while the block is idle.
// Timing: an accepted character waits in the input register until the queue
//   has room; its results are then written there and offered on out_*.
// Throughput: one character per cycle. A final character that also
//   completes a byte gives two results; the four-entry result queue then
//   drains one per cycle and input is held off when fewer than two entries
//   are free.
// Receiver stall: results wait in the queue, the input register holds the
//   pending character and in_ready drops; nothing is lost.
// Reset: clears the queue, the decode state and the capacity (no limit).
module base64_stream_decoder_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  b64d_pkg::in_t                   in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output b64d_pkg::out_t                  out_data,
    input  logic                            cfg_wr_en,
    input  logic [b64d_pkg::CAP_BITS-1:0]   cfg_wr_data
);
    import b64d_pkg::*;

    push_t push;
    logic  room;

    b64d_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .room        (room),
        .push        (push)
    );

    b64d_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

>>> src/b64d_checker.sv
// Port-level checks on the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and base64_stream_decoder_core.
module b64d_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic                            in_ready,
    input  b64d_pkg::in_t                   in_data,
    input  logic                            out_valid,
    input  logic                            out_ready,
    input  b64d_pkg::out_t                  out_data,
    input  logic                            cfg_wr_en,
    input  logic [b64d_pkg::CAP_BITS-1:0]   cfg_wr_data
);
    import b64d_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_DATA |->
            out_data.status == STATUS_OK && out_data.byte_total == '0)
        else $error("data result carries report fields");

    a_report_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.kind == KIND_REPORT |-> out_data.data_byte == 8'h00)
        else $error("report carries a data byte");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result offered straight out of reset");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (.*);

>>> tb/base64_stream_decoder_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for base64_stream_decoder_core: random and directed text, byte capacity
// sweeps, back-pressure on both sides. Depends on b64d_pkg and the decoder RTL only.
module base64_stream_decoder_core_tb;

    import b64d_pkg::*;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    in_t                 in_data     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    out_t                out_data;
    logic                cfg_wr_en   = 1'b0;
    logic [CAP_BITS-1:0] cfg_wr_data = '0;

    // decode state mirrored from the block
    logic [1:0]            quad_phase   = '0;
    logic [7:0]            partial_byte = '0;
    logic                  halted       = 1'b0;
    logic                  pad_check    = 1'b0;
    logic                  overrun_seen = 1'b0;
    logic [COUNT_BITS-1:0] byte_count   = '0;
    logic [CAP_BITS-1:0]   capacity     = '0;

    in_t         text_chars[$];
    out_t        decode_due[$];
    logic        in_taken       = 1'b0;
    int unsigned accepted_chars = 0;
    int unsigned queued_chars   = 0;
    int unsigned error_count    = 0;
    int unsigned send_gap       = 0;
    int unsigned recv_gap       = 0;
    int unsigned send_idle_pct  = 10;
    int unsigned recv_idle_pct  = 10;
    logic        no_idling      = 1'b0;
    logic        long_hold      = 1'b0;

    localparam logic [7:0] FILLER[4] = '{8'h20, 8'h0A, 8'h0D, 8'h09};

    base64_stream_decoder_core DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [6:0] char_symbol(input logic [7:0] c);
        if (c >= "A" && c <= "Z")
            return 7'(c - "A");
        if (c >= "a" && c <= "z")
            return 7'(c - "a" + 8'd26);
        if (c >= "0" && c <= "9")
            return 7'(c - "0" + 8'd52);
        if (c == "+")
            return 7'd62;
        if (c == "/")
            return 7'd63;
        if (c == CHAR_PAD)
            return SYM_PAD;
        return SYM_SKIP;
    endfunction

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        return (v == 6'd62) ? 8'h2B : 8'h2F;
    endfunction

    function automatic int unsigned pick_idle_rate();
        case ($urandom_range(3))
            0:       return 0;
            1:       return 10;
            2:       return 30;
            default: return 60;
        endcase
    endfunction

    task automatic decode_char(input in_t item);
        logic [6:0] sym;
        logic [7:0] byte_val;
        logic [1:0] phase;
        out_t       res;
        sym      = char_symbol(item.char_in);
        byte_val = '0;
        phase    = quad_phase;
        if (!halted)
        begin
            if (pad_check)
            begin
                pad_check = 1'b0;
                halted    = 1'b1;
                if (item.char_in != CHAR_PAD)
                    overrun_seen = 1'b1;
            end
            else if (sym == SYM_PAD)
            begin
                if (quad_phase == 2'd0)
                    halted = 1'b1;
                quad_phase   = '0;
                partial_byte = '0;
            end
            else if (sym != SYM_SKIP)
            begin
                case (phase)
                    2'd0: partial_byte = {sym[5:0], 2'b00};
                    2'd1:
                    begin
                        byte_val     = partial_byte | {6'b0, sym[5:4]};
                        partial_byte = {sym[3:0], 4'b0000};
                    end
                    2'd2:
                    begin
                        byte_val     = partial_byte | {4'b0, sym[5:2]};
                        partial_byte = {sym[1:0], 6'b000000};
                    end
                    default:
                    begin
                        byte_val     = partial_byte | {2'b0, sym[5:0]};
                        partial_byte = '0;
                    end
                endcase
                quad_phase = phase + 2'd1;
                if (phase != 2'd0)
                begin
                    res           = '0;
                    res.kind      = KIND_DATA;
                    res.data_byte = byte_val;
                    decode_due.push_back(res);
                    if (byte_count != '1)
                        byte_count = byte_count + 1'b1;
                    if (capacity != '0 && byte_count >= capacity)
                    begin
                        if (phase == 2'd3)
                            halted = 1'b1;
                        else if (item.msg_end)
                        begin
                            halted       = 1'b1;
                            overrun_seen = 1'b1;
                        end
                        else
                            pad_check = 1'b1;
                    end
                end
            end
        end
        if (item.msg_end)
        begin
            res            = '0;
            res.kind       = KIND_REPORT;
            res.status     = overrun_seen ? STATUS_OVERRUN : STATUS_OK;
            res.byte_total = TOTAL_BITS'(byte_count);
            decode_due.push_back(res);
            quad_phase   = '0;
            partial_byte = '0;
            halted       = 1'b0;
            pad_check    = 1'b0;
            overrun_seen = 1'b0;
            byte_count   = '0;
        end
    endtask

    task automatic report_error(input string what, input out_t want, input out_t got);
        error_count++;
        if (error_count <= 10)
            $display("%0t %s: expected kind=%0d byte=%02h status=%0d total=%0d,",
                     $time, what, want.kind, want.data_byte, want.status, want.byte_total,
                     " got kind=%0d byte=%02h status=%0d total=%0d",
                     got.kind, got.data_byte, got.status, got.byte_total);
    endtask

    // monitor: predict on accepted characters, check accepted results
    always @(posedge clk)
    begin : monitor
        out_t want;
        if (!rst_n)
            in_taken <= 1'b0;
        else
        begin
            in_taken <= in_valid && in_ready;
            if (cfg_wr_en)
                capacity = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                decode_char(in_data);
                accepted_chars++;
            end
            if (out_valid && out_ready)
            begin
                if (decode_due.size() == 0)
                    report_error("unexpected result", '0, out_data);
                else
                begin
                    want = decode_due.pop_front();
                    if (out_data.kind !== want.kind || out_data.data_byte !== want.data_byte ||
                        out_data.status !== want.status ||
                        out_data.byte_total !== want.byte_total)
                        report_error("mismatch", want, out_data);
                end
            end
        end
    end

    // sender
    always @(negedge clk)
    begin
        if ($urandom_range(127) == 0)
            send_idle_pct <= pick_idle_rate();
        if (!rst_n)
            in_valid <= 1'b0;
        else if (in_valid && !in_taken)
            in_valid <= 1'b1;
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            in_valid <= 1'b0;
        end
        else if (!no_idling && $urandom_range(99) < send_idle_pct)
        begin
            send_gap <= $urandom_range(8);
            in_valid <= 1'b0;
        end
        else if (text_chars.size() > 0)
        begin
            in_valid <= 1'b1;
            in_data  <= text_chars.pop_front();
        end
        else
            in_valid <= 1'b0;
    end

    // receiver
    always @(negedge clk)
    begin
        if ($urandom_range(127) == 0)
            recv_idle_pct <= pick_idle_rate();
        if (recv_gap > 0)
        begin
            recv_gap  <= recv_gap - 1;
            out_ready <= 1'b0;
        end
        else if (long_hold)
            out_ready <= 1'b0;
        else if (!no_idling && $urandom_range(99) < recv_idle_pct)
        begin
            recv_gap  <= $urandom_range(8);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // long receiver hold-off so the result queue fills and input stalls
    initial
    begin
        wait (accepted_chars >= 480);
        @(posedge clk);
        long_hold = 1'b1;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic queue_char(input logic [7:0] c, input logic last);
        in_t item;
        item.char_in = c;
        item.msg_end = last;
        text_chars.push_back(item);
        queued_chars++;
    endtask

    task automatic queue_chars(input string s, input logic mark_end);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i], mark_end && i == s.len() - 1);
    endtask

    task automatic queue_message();
        logic [7:0]  text[$];
        logic [23:0] grp;
        int unsigned n;
        int unsigned style;
        bit          with_pad;
        style = $urandom_range(99);
        if (style < 70)
        begin
            n        = $urandom_range(14);
            with_pad = $urandom_range(4) != 0;
            for (int i = 0; i < n; i += 3)
            begin
                grp = 24'($urandom);
                text.push_back(b64_char(grp[23:18]));
                text.push_back(b64_char(grp[17:12]));
                if (n - i >= 2)
                    text.push_back(b64_char(grp[11:6]));
                else if (with_pad)
                    text.push_back(CHAR_PAD);
                if (n - i >= 3)
                    text.push_back(b64_char(grp[5:0]));
                else if (with_pad)
                    text.push_back(CHAR_PAD);
            end
            repeat ($urandom_range(2))
                text.insert($urandom_range(text.size()), FILLER[$urandom_range(3)]);
            // broken variants
            if (style >= 55)
            begin
                case ($urandom_range(2))
                    0: text.insert($urandom_range(text.size()), CHAR_PAD);
                    1: if (text.size() > 0) text.delete($urandom_range(text.size() - 1));
                    default:
                        repeat ($urandom_range(4, 1))
                            text.push_back(b64_char(6'($urandom_range(63))));
                endcase
            end
        end
        else if (style < 85)
        begin
            repeat ($urandom_range(12, 1))
                text.push_back(($urandom_range(15) == 0) ? CHAR_PAD
                                                         : b64_char(6'($urandom_range(63))));
        end
        else
        begin
            repeat ($urandom_range(8, 1))
                text.push_back(8'($urandom_range(255)));
        end
        if (text.size() == 0)
            text.push_back(FILLER[$urandom_range(3)]);
        foreach (text[i])
            queue_char(text[i], i == text.size() - 1);
    endtask

    task automatic drain();
        do
            @(posedge clk);
        while (text_chars.size() != 0 || in_valid || decode_due.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_BITS-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin
        logic [CAP_BITS-1:0] phase_caps[8];
        int unsigned         target;
        phase_caps = '{24'd0, 24'hFFFFFF, 24'd2, 24'd5, 24'($urandom_range(14, 1)),
                       24'd1, 24'd7, 24'd0};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no limit: ends of each alphabet range, extreme codes, pad mid-quad then at quad start
        queue_chars("AZaz09+/", 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_chars("A==Q", 1'b1);
        drain();

        // capacity of one byte: padded, overrun on next char, overrun on last char
        write_capacity(24'd1);
        queue_chars("QU=", 1'b1);
        queue_chars("QUJ", 1'b1);
        queue_chars("QU", 1'b1);
        drain();

        // capacity of three: message ends mid-quad, then clean stop on a full quad
        write_capacity(24'd3);
        queue_chars("QUJ", 1'b1);
        queue_chars("QUJDQ", 1'b1);
        drain();

        foreach (phase_caps[p])
        begin
            write_capacity(phase_caps[p]);
            if (p == 7)
                no_idling = 1'b1;
            target = queued_chars + 185;
            while (queued_chars < target)
                queue_message();
            drain();
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
src/b64d_pkg.sv
src/b64d_out_fifo.sv
src/b64d_core.sv
src/base64_stream_decoder_core.sv
src/b64d_checker.sv
tb/base64_stream_decoder_core_tb.sv
